// File: rtl/wotz_pkg.sv
// ----------------------------------------------------------------------------
// wotz_pkg
// Shared types and constants for the 2-D trapezoid overlap integrator.
// ----------------------------------------------------------------------------
package wotz_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_W      = 9;
  localparam int STEP_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MESH_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MESH_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y    = 2'd3;

  localparam logic [CNT_W-1:0]  MESH_ROWS_RST = 9'd256;
  localparam logic [CNT_W-1:0]  MESH_COLS_RST = 9'd256;
  localparam logic [STEP_W-1:0] STEP_RST      = 16'hFFFF;

  // default mesh limits
  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 256;

  // shared multiplier operand and product widths
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // triple product width (Q3.45)
  localparam int TRIP_W = 48;

  localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [15:0] field_a_sample;
    logic signed [15:0] field_b_sample;
    logic signed [15:0] gradient_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] integral_value;
    logic               saturated;
  } out_item_t;

  // sequencer to accumulator
  typedef struct packed {
    logic add;
    logic clear;
  } acc_ctrl_t;

  // accumulator to sequencer
  typedef struct packed {
    logic mesh_end;
    logic clipped;
  } acc_stat_t;

endpackage

// File: rtl/wotz_mul.sv
// ----------------------------------------------------------------------------
// wotz_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module wotz_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [wotz_pkg::MUL_W-1:0]     op_a,
  input  logic signed [wotz_pkg::MUL_W-1:0]     op_b,
  output logic signed [wotz_pkg::PROD_W-1:0]    prod
);

  logic signed [wotz_pkg::PROD_W-1:0] prod_r;

  // product register, loaded only when the sequencer issues an operation
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod = prod_r;

endmodule

// File: rtl/wotz_acc.sv
// ----------------------------------------------------------------------------
// wotz_acc
// Mesh position tracking, trapezoid weighting and saturating accumulation.
// ----------------------------------------------------------------------------
module wotz_acc #(
  parameter int MAX_ROWS = wotz_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = wotz_pkg::DEF_MAX_COLS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wotz_pkg::acc_ctrl_t                  ctrl,
  input  logic signed [wotz_pkg::TRIP_W-1:0]   term_in,
  input  logic [wotz_pkg::CNT_W-1:0]           mesh_rows,
  input  logic [wotz_pkg::CNT_W-1:0]           mesh_cols,
  output logic signed [63:0]                   sum,
  output wotz_pkg::acc_stat_t                  stat
);

  localparam int RIW = $clog2(MAX_ROWS);
  localparam int CIW = $clog2(MAX_COLS);
  localparam int RCW = ($clog2(MAX_ROWS + 1) > wotz_pkg::CNT_W) ?
                       $clog2(MAX_ROWS + 1) : wotz_pkg::CNT_W;
  localparam int CCW = ($clog2(MAX_COLS + 1) > wotz_pkg::CNT_W) ?
                       $clog2(MAX_COLS + 1) : wotz_pkg::CNT_W;

  logic [RIW-1:0]     row_idx_r, row_idx_nxt;
  logic [CIW-1:0]     col_idx_r, col_idx_nxt;
  logic signed [63:0] sum_r, sum_nxt;
  logic               clip_r, clip_nxt;

  logic [RCW-1:0]     rows_ext, rows_c, row_ext;
  logic [CCW-1:0]     cols_ext, cols_c, col_ext;
  logic               last_row, last_col;
  logic [1:0]         row_w, col_w;
  logic [1:0]         shift;
  logic               w_zero;
  logic signed [63:0] term;
  logic signed [64:0] sum_wide;

  // clamp counts: zero acts as one, above the limit acts as the limit
  always_comb begin
    rows_ext = RCW'(mesh_rows);
    cols_ext = CCW'(mesh_cols);
    if (rows_ext == '0) begin
      rows_c = RCW'(1);
    end else if (rows_ext > RCW'(MAX_ROWS)) begin
      rows_c = RCW'(MAX_ROWS);
    end else begin
      rows_c = rows_ext;
    end
    if (cols_ext == '0) begin
      cols_c = CCW'(1);
    end else if (cols_ext > CCW'(MAX_COLS)) begin
      cols_c = CCW'(MAX_COLS);
    end else begin
      cols_c = cols_ext;
    end
  end

  // position and axis weights (0 for a single line, 1 at the ends, 2 inside)
  always_comb begin
    row_ext  = RCW'(row_idx_r);
    col_ext  = CCW'(col_idx_r);
    last_row = (row_ext >= rows_c - RCW'(1));
    last_col = (col_ext >= cols_c - CCW'(1));
    if (rows_c < RCW'(2)) begin
      row_w = 2'd0;
    end else if ((row_idx_r == '0) || last_row) begin
      row_w = 2'd1;
    end else begin
      row_w = 2'd2;
    end
    if (cols_c < CCW'(2)) begin
      col_w = 2'd0;
    end else if ((col_idx_r == '0) || last_col) begin
      col_w = 2'd1;
    end else begin
      col_w = 2'd2;
    end
    w_zero = (row_w == 2'd0) || (col_w == 2'd0);
    shift  = {1'b0, row_w[1]} + {1'b0, col_w[1]};
  end

  // weighted term: a nonzero weight is a power of two
  always_comb begin
    if (w_zero) begin
      term = '0;
    end else begin
      term = 64'(term_in) <<< shift;
    end
  end

  // saturating add, frozen once clipped until clear; the mesh position advances on every add
  always_comb begin
    sum_wide    = {sum_r[63], sum_r} + {term[63], term};
    sum_nxt     = sum_r;
    clip_nxt    = clip_r;
    row_idx_nxt = row_idx_r;
    col_idx_nxt = col_idx_r;
    if (ctrl.clear) begin
      sum_nxt  = '0;
      clip_nxt = 1'b0;
    end else if (ctrl.add) begin
      if (!clip_r) begin
        if (sum_wide[64] != sum_wide[63]) begin
          sum_nxt  = sum_wide[64] ? wotz_pkg::SUM_MIN : wotz_pkg::SUM_MAX;
          clip_nxt = 1'b1;
        end else begin
          sum_nxt = sum_wide[63:0];
        end
      end
      if (!last_row) begin
        row_idx_nxt = row_idx_r + RIW'(1);
      end else begin
        row_idx_nxt = '0;
        if (!last_col) begin
          col_idx_nxt = col_idx_r + CIW'(1);
        end else begin
          col_idx_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_idx_r <= '0;
      col_idx_r <= '0;
      sum_r     <= '0;
      clip_r    <= 1'b0;
    end else begin
      row_idx_r <= row_idx_nxt;
      col_idx_r <= col_idx_nxt;
      sum_r     <= sum_nxt;
      clip_r    <= clip_nxt;
    end
  end

  assign sum           = sum_r;
  assign stat.mesh_end = last_row && last_col;
  assign stat.clipped  = clip_r;

endmodule

// File: rtl/weighted_overlap_trapz_2d.sv
// ----------------------------------------------------------------------------
// weighted_overlap_trapz_2d
// Trapezoid-rule overlap integral of two fields and a gradient over a mesh.
// ----------------------------------------------------------------------------
// Samples arrive column-major, row index fastest, one word per sample. Each
// sample passes through accept and first product (S_IDLE), second product
// (S_MUL2) and weighted accumulate (S_ACC), one product at a time on the
// single shared 33x33 multiplier, so in_stall is high after every accepted
// word until S_IDLE is reached again. After the last sample of the mesh the
// sum is scaled by step_x*step_y/4 using the same multiplier (3 products),
// which keeps in_stall high through S_FIN, S_P, S_LO, S_HI and S_OUT, plus
// any time the previous result still sits unread in the output register.
// An accumulator that clipped is returned unscaled at its rail with
// saturated set; the scaling pass is then skipped and in_stall stays high
// only through S_FIN and S_OUT. Configuration is only to be written while the block is idle.
// ----------------------------------------------------------------------------
module weighted_overlap_trapz_2d #(
  parameter int MAX_ROWS = wotz_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = wotz_pkg::DEF_MAX_COLS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  wotz_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output wotz_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [wotz_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wotz_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL2 = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_P    = 3'd4;
  localparam logic [2:0] S_LO   = 3'd5;
  localparam logic [2:0] S_HI   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  localparam int MW = wotz_pkg::MUL_W;

  logic [2:0] state_r, state_nxt;

  logic [wotz_pkg::CNT_W-1:0]  mesh_rows_r, mesh_cols_r;
  logic [wotz_pkg::STEP_W-1:0] step_x_r, step_y_r;

  logic signed [15:0]  grad_r;
  logic                neg_r;
  logic [63:0]         mag_r;
  logic signed [63:0]  raw_r;
  logic                clip_r;
  logic [31:0]         p_r;
  logic [63:0]         lo_r;
  logic [63:0]         q_r;
  logic                sum_pend_r;

  logic                out_valid_r;
  wotz_pkg::out_item_t out_data_r;

  logic                        mul_en;
  logic signed [MW-1:0]        mul_a, mul_b;
  logic signed [2*MW-1:0]      mul_q;
  wotz_pkg::acc_ctrl_t         acc_ctrl;
  wotz_pkg::acc_stat_t         acc_stat;
  logic signed [63:0]          acc_sum;

  logic                in_acc;
  logic                out_free;
  logic [95:0]         full;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mesh_rows_r <= wotz_pkg::MESH_ROWS_RST;
      mesh_cols_r <= wotz_pkg::MESH_COLS_RST;
      step_x_r    <= wotz_pkg::STEP_RST;
      step_y_r    <= wotz_pkg::STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wotz_pkg::REG_MESH_ROWS: mesh_rows_r <= cfg_wdata[wotz_pkg::CNT_W-1:0];
        wotz_pkg::REG_MESH_COLS: mesh_cols_r <= cfg_wdata[wotz_pkg::CNT_W-1:0];
        wotz_pkg::REG_STEP_X:    step_x_r    <= cfg_wdata;
        wotz_pkg::REG_STEP_Y:    step_y_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer: multiplier operand select and state flow
  always_comb begin
    state_nxt      = state_r;
    mul_en         = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    acc_ctrl.add   = 1'b0;
    acc_ctrl.clear = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        mul_a = MW'(in_data.field_a_sample);
        mul_b = MW'(in_data.field_b_sample);
        if (in_acc) begin
          mul_en    = 1'b1;
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        mul_en    = 1'b1;
        mul_a     = mul_q[MW-1:0];
        mul_b     = MW'(grad_r);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_ctrl.add = 1'b1;
        state_nxt    = acc_stat.mesh_end ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        acc_ctrl.clear = 1'b1;
        state_nxt      = acc_stat.clipped ? S_OUT : S_P;
      end
      S_P: begin
        mul_en    = 1'b1;
        mul_a     = MW'(step_x_r);
        mul_b     = MW'(step_y_r);
        state_nxt = S_LO;
      end
      S_LO: begin
        mul_en    = 1'b1;
        mul_a     = MW'(mag_r[31:0]);
        mul_b     = MW'(mul_q[31:0]);
        state_nxt = S_HI;
      end
      S_HI: begin
        mul_en    = 1'b1;
        mul_a     = MW'(mag_r[63:32]);
        mul_b     = MW'(p_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!sum_pend_r && out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // scaling: round(|sum| * p / 2^34) to nearest, ties away from zero
  assign full = {32'd0, lo_r} + {mul_q[63:0], 32'd0} + 96'h2_0000_0000;

  // datapath registers of the per-sample gradient and the scaling pass
  always_ff @(posedge clk) begin
    if (in_acc) begin
      grad_r <= in_data.gradient_sample;
    end
    if (state_r == S_FIN) begin
      neg_r  <= acc_sum[63];
      mag_r  <= acc_sum[63] ? (64'd0 - acc_sum) : acc_sum;
      raw_r  <= acc_sum;
      clip_r <= acc_stat.clipped;
    end
    if (state_r == S_LO) begin
      p_r <= mul_q[31:0];
    end
    if (state_r == S_HI) begin
      lo_r <= mul_q[63:0];
    end
    if (sum_pend_r) begin
      q_r <= {2'b00, full[95:34]};
    end
  end

  // the rounding sum is registered in the cycle after the high partial product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_pend_r <= 1'b0;
    end else begin
      sum_pend_r <= (state_r == S_HI);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && !sum_pend_r && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && !sum_pend_r && out_free) begin
      if (clip_r) begin
        out_data_r.integral_value <= raw_r;
        out_data_r.saturated      <= 1'b1;
      end else begin
        out_data_r.integral_value <= neg_r ? (64'd0 - q_r) : q_r;
        out_data_r.saturated      <= 1'b0;
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  wotz_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_q)
  );

  wotz_acc #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (acc_ctrl),
    .term_in   (mul_q[wotz_pkg::TRIP_W-1:0]),
    .mesh_rows (mesh_rows_r),
    .mesh_cols (mesh_cols_r),
    .sum       (acc_sum),
    .stat      (acc_stat)
  );

endmodule

// File: rtl/wotz_chk.sv
// ----------------------------------------------------------------------------
// wotz_chk
// Port-level checks for the trapezoid overlap integrator.
// ----------------------------------------------------------------------------
module wotz_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input wotz_pkg::out_item_t                  out_data
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // an accepted sample holds in_stall high in the next cycle while the shared multiplier works
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("next word taken before the sample finished");

  // a new result only comes out of a busy block, with in_stall high before it rises
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while the block was idle");

  // a clipped result sits on a 64-bit rail
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.integral_value == wotz_pkg::SUM_MAX) ||
      (out_data.integral_value == wotz_pkg::SUM_MIN))
    else $error("saturated result off the rail");

endmodule

bind weighted_overlap_trapz_2d wotz_chk u_chk (.*);
